### rtl/chained_hash_map_engine_macros.svh
// Assertion macros for the chained hash map engine.
// Used by the top level; no other dependencies.
`ifndef CHAINED_HASH_MAP_ENGINE_MACROS_SVH
`define CHAINED_HASH_MAP_ENGINE_MACROS_SVH

// same-cycle implication
`define CHM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/chm_pkg.sv
// Shared constants and codes for the chained hash map engine.
// No dependencies.
package chm_pkg;
   localparam int NUM_BUCKETS = 16;
   localparam int NUM_SLOTS   = 64;
   localparam int BKT_W       = 4;   // bucket index
   localparam int SLOT_W      = 6;   // slot address
   localparam int LINK_W      = 7;   // slot index plus null
   localparam int BCNT_W      = 5;   // bucket count register
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;

   localparam logic [LINK_W-1:0] NULL_IDX = LINK_W'(NUM_SLOTS);
   localparam logic [BCNT_W-1:0] MAX_BCNT = BCNT_W'(NUM_BUCKETS);

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REM    = 2'd1;
   localparam logic [1:0] FUNC_GET    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND  = 2'd2;
   localparam logic [1:0] ST_ZERO_VALUE = 2'd3;

   typedef struct packed {
      logic              done;
      logic [BKT_W-1:0]  rem;
   } mod_stat_type;
endpackage

### rtl/chm_mod_unit.sv
// Iterative remainder unit: 32-bit key modulo a bucket count of 1..16,
// four quotient bits per cycle. Depends on chm_pkg.
module chm_mod_unit import chm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [KEY_W-1:0]  dividend,
   input  logic [BCNT_W-1:0] divisor,
   output mod_stat_type      stat
);
   logic [KEY_W-1:0]  dvd_ff, dvd_in;
   logic [BCNT_W-1:0] div_ff, div_in;
   logic [BCNT_W-1:0] rem_ff, rem_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      logic [BCNT_W-1:0] r;
      r       = rem_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 4; i++) begin
            r = {r[BCNT_W-2:0], dvd_ff[KEY_W-1-i]};
            if (r >= div_ff) r = r - div_ff;
         end
         rem_in = r;
         dvd_in = {dvd_ff[KEY_W-5:0], 4'b0};
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff[BKT_W-1:0];
endmodule

### rtl/chained_hash_map_engine.sv
// Chained hash map engine: key/value map, 16 buckets over a 64-slot pool.
// Depends on chm_pkg, chm_mod_unit and chained_hash_map_engine_macros.svh.
//
// One transaction at a time. A lookup runs the bucket remainder unit, then
// walks the chain, WALK and CMP for each entry compared; a new add then
// allocates a slot in ALLOC1 and ALLOC2, and a remove that hits frees it in
// REM2. An add of a zero value and the unused selector go straight to the
// response. The bucket remainder unit is iterative (eight iterations and its
// done register), and the chain walk is bound by the one registered read port
// of the slot memories. Reset and every write of bucket_count start a pass
// over all 64 slots that relinks the free list; no request is taken during
// it. A result waits in an output register, and a stalled response holds the
// engine until that register is free.
`include "chained_hash_map_engine_macros.svh"
module chained_hash_map_engine import chm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [71:0]       req_tdata,   // func[1:0], key[33:2], value[65:34], zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,   // status[1:0], read_value[33:2], zero pad
   input  logic              csr_we,
   input  logic [BCNT_W-1:0] csr_wdata
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MOD    = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_CMP    = 4'd3;
   localparam logic [3:0] S_REM2   = 4'd4;
   localparam logic [3:0] S_ALLOC1 = 4'd5;
   localparam logic [3:0] S_ALLOC2 = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   logic [3:0]        state_ff, state_in;
   logic [BCNT_W-1:0] bcnt_ff;
   logic              clr_ff;
   logic [SLOT_W-1:0] clr_cnt_ff;
   logic [LINK_W-1:0] head_ff [NUM_BUCKETS];
   logic [LINK_W-1:0] head_in [NUM_BUCKETS];
   logic [LINK_W-1:0] free_ff, free_in;
   logic [1:0]        func_ff, func_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [1:0]        stat_ff, stat_in;
   logic [VAL_W-1:0]  rval_ff, rval_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_stat_ff, rsp_stat_in;
   logic [VAL_W-1:0]  rsp_val_ff, rsp_val_in;

   logic [KEY_W-1:0]  slot_key  [NUM_SLOTS];
   logic [VAL_W-1:0]  slot_value[NUM_SLOTS];
   logic [LINK_W-1:0] slot_link [NUM_SLOTS];
   logic [KEY_W-1:0]  key_q;
   logic [VAL_W-1:0]  value_q;
   logic [LINK_W-1:0] link_q;
   logic [SLOT_W-1:0] rd_addr;

   logic              kv_we, val_we, lk_we, lk_we_fsm;
   logic [SLOT_W-1:0] kv_addr, lk_addr, lk_addr_fsm;
   logic [LINK_W-1:0] lk_wdata, lk_wdata_fsm;

   logic              accept, mod_start;
   logic [BCNT_W-1:0] n_bkt;
   mod_stat_type      mod_stat;

   assign n_bkt = (bcnt_ff == '0) ? BCNT_W'(1) :
                  (bcnt_ff > MAX_BCNT) ? MAX_BCNT : bcnt_ff;

   assign req_tready = (state_ff == S_IDLE) && !clr_ff;
   assign accept     = req_tvalid && req_tready;

   chm_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (req_tdata[33:2]),
      .divisor  (n_bkt),
      .stat     (mod_stat)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      free_in      = free_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      bkt_in       = bkt_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      stat_in      = stat_ff;
      rval_in      = rval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_val_in   = rsp_val_ff;
      mod_start    = 1'b0;
      rd_addr      = cur_ff[SLOT_W-1:0];
      kv_we        = 1'b0;
      val_we       = 1'b0;
      kv_addr      = cur_ff[SLOT_W-1:0];
      lk_we_fsm    = 1'b0;
      lk_addr_fsm  = cur_ff[SLOT_W-1:0];
      lk_wdata_fsm = free_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_tdata[1:0];
               key_in  = req_tdata[33:2];
               val_in  = req_tdata[65:34];
               stat_in = ST_OK;
               rval_in = '0;
               if (req_tdata[1:0] == FUNC_ADD && req_tdata[65:34] == '0) begin
                  stat_in  = ST_ZERO_VALUE;
                  state_in = S_RESP;
               end else if (req_tdata[1:0] == FUNC_ADD || req_tdata[1:0] == FUNC_REM ||
                            req_tdata[1:0] == FUNC_GET) begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_MOD: begin
            if (mod_stat.done) begin
               bkt_in   = mod_stat.rem;
               cur_in   = head_ff[mod_stat.rem];
               prev_in  = NULL_IDX;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (cur_ff == NULL_IDX) begin
               if (func_ff == FUNC_ADD) begin
                  if (free_ff == NULL_IDX) begin
                     stat_in  = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_ALLOC1;
                  end
               end else begin
                  stat_in  = ST_NOT_FOUND;
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (key_q == key_ff) begin
               if (func_ff == FUNC_ADD) begin
                  val_we   = 1'b1;
                  state_in = S_RESP;
               end else if (func_ff == FUNC_REM) begin
                  // unlink from predecessor or bucket head
                  if (prev_ff == NULL_IDX) begin
                     head_in[bkt_ff] = link_q;
                  end else begin
                     lk_we_fsm    = 1'b1;
                     lk_addr_fsm  = prev_ff[SLOT_W-1:0];
                     lk_wdata_fsm = link_q;
                  end
                  state_in = S_REM2;
               end else begin
                  rval_in  = value_q;
                  state_in = S_RESP;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_q;
               state_in = S_WALK;
            end
         end
         S_REM2: begin
            lk_we_fsm    = 1'b1;
            lk_addr_fsm  = cur_ff[SLOT_W-1:0];
            lk_wdata_fsm = free_ff;
            free_in      = cur_ff;
            state_in     = S_RESP;
         end
         S_ALLOC1: begin
            rd_addr  = free_ff[SLOT_W-1:0];
            state_in = S_ALLOC2;
         end
         S_ALLOC2: begin
            // pop free list, push slot on chain front
            kv_we           = 1'b1;
            val_we          = 1'b1;
            kv_addr         = free_ff[SLOT_W-1:0];
            lk_we_fsm       = 1'b1;
            lk_addr_fsm     = free_ff[SLOT_W-1:0];
            lk_wdata_fsm    = head_ff[bkt_ff];
            head_in[bkt_ff] = free_ff;
            free_in         = link_q;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = stat_ff;
               rsp_val_in   = rval_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign lk_we    = clr_ff || lk_we_fsm;
   assign lk_addr  = clr_ff ? clr_cnt_ff : lk_addr_fsm;
   assign lk_wdata = clr_ff ? ({1'b0, clr_cnt_ff} + LINK_W'(1)) : lk_wdata_fsm;

   always_ff @(posedge clock) begin
      if (kv_we) slot_key[kv_addr] <= key_ff;
      if (val_we) slot_value[kv_addr] <= val_ff;
      if (lk_we) slot_link[lk_addr] <= lk_wdata;
      key_q   <= slot_key[rd_addr];
      value_q <= slot_value[rd_addr];
      link_q  <= slot_link[rd_addr];
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      bkt_ff      <= bkt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      stat_ff     <= stat_in;
      rval_ff     <= rval_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_val_ff  <= rsp_val_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         bcnt_ff      <= MAX_BCNT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) bcnt_ff <= csr_wdata;
      end
      if (reset || csr_we) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         free_ff    <= '0;
         for (int i = 0; i < NUM_BUCKETS; i++) head_ff[i] <= NULL_IDX;
      end else begin
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SLOT_W'(NUM_SLOTS - 1)) clr_ff <= 1'b0;
         end
         free_ff <= free_in;
         head_ff <= head_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_val_ff, rsp_stat_ff};

   `CHM_ASSERT_NOW(a_no_req_in_clear, clock, reset, clr_ff, !req_tready,
                   "request taken during free list pass")
   `CHM_ASSERT_NOW(a_bucket_range, clock, reset, mod_stat.done,
                   {1'b0, mod_stat.rem} < n_bkt, "bucket index beyond count")
   `CHM_ASSERT_NOW(a_free_range, clock, reset, 1'b1, free_ff <= NULL_IDX,
                   "free head beyond null index")
   `CHM_ASSERT_NEXT(a_resp_follows, clock, reset,
                    state_ff == S_RESP && (!rsp_valid_ff || rsp_tready),
                    rsp_valid_ff && state_ff == S_IDLE, "result not loaded")
endmodule
